/* rtl/pac_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pac_pkg
// Types and constants shared by the proximity autohide controller.
// ----------------------------------------------------------------------------
package pac_pkg;

  // strip width along the screen edge while the panel is hidden (1 to 64)
  localparam int EDGE_STRIP = 2;

  // width of the bound arithmetic, wide enough for left + width +/- strip
  localparam int CW = 19;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_PANEL_LEFT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_TOP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_EDGE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HIDE_DELAY   = 3'd5;

  localparam logic [1:0] SIDE_LEFT   = 2'd0;
  localparam logic [1:0] SIDE_RIGHT  = 2'd1;
  localparam logic [1:0] SIDE_TOP    = 2'd2;
  localparam logic [1:0] SIDE_BOTTOM = 2'd3;

  typedef enum logic [1:0] {
    MODE_VISIBLE = 2'd0,
    MODE_WAITING = 2'd1,
    MODE_HIDDEN  = 2'd2
  } mode_t;

  typedef struct packed {
    logic signed [15:0] pointer_x;
    logic signed [15:0] pointer_y;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] mode_now;
    logic       panel_shown;
    logic       pointer_far;
  } out_beat_t;

endpackage
`default_nettype wire

/* rtl/proximity_autohide_controller.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// proximity_autohide_controller
// Pointer proximity test against the panel rectangle and autohide state.
// ----------------------------------------------------------------------------
// One pointer sample is accepted per clock cycle unless in_stall is high.
// A sample is captured in an input register, tested against the panel
// bounds (or the edge strip while hidden) and the autohide state is
// advanced in the same cycle; the result beat is then held in an output
// register, and a stalled output side holds the input register.
// The rate is set by the single state update per sample. Configuration
// registers must only be written while no sample is in flight.
module proximity_autohide_controller (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire pac_pkg::in_beat_t                 in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output pac_pkg::out_beat_t                     out_data,
  input  wire logic                              cfg_we,
  input  wire logic [pac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pac_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CW = pac_pkg::CW;
  localparam logic signed [CW-1:0] STRIP_W = CW'(pac_pkg::EDGE_STRIP);

  // configuration
  logic signed [15:0] panel_left;
  logic signed [15:0] panel_top;
  logic        [14:0] panel_width;
  logic        [14:0] panel_height;
  logic        [1:0]  screen_edge;
  logic        [7:0]  hide_delay;

  // state
  pac_pkg::mode_t mode;
  pac_pkg::mode_t mode_next;
  logic [7:0]     wait_count;
  logic [7:0]     wait_count_next;

  // pipeline
  logic               s1_valid;
  pac_pkg::in_beat_t  s1_data;
  logic               s1_move;
  pac_pkg::out_beat_t result;

  // bounds
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;
  logic signed [CW-1:0] left_ext;
  logic signed [CW-1:0] top_ext;
  logic signed [CW-1:0] width_ext;
  logic signed [CW-1:0] height_ext;
  logic signed [CW-1:0] lo_x;
  logic signed [CW-1:0] hi_x;
  logic signed [CW-1:0] lo_y;
  logic signed [CW-1:0] hi_y;
  logic                 far;
  logic [7:0]           wait_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_left   <= '0;
      panel_top    <= '0;
      panel_width  <= '0;
      panel_height <= '0;
      screen_edge  <= pac_pkg::SIDE_BOTTOM;
      hide_delay   <= 8'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        pac_pkg::REG_PANEL_LEFT:   panel_left   <= cfg_data;
        pac_pkg::REG_PANEL_TOP:    panel_top    <= cfg_data;
        pac_pkg::REG_PANEL_WIDTH:  panel_width  <= cfg_data[14:0];
        pac_pkg::REG_PANEL_HEIGHT: panel_height <= cfg_data[14:0];
        pac_pkg::REG_SCREEN_EDGE:  screen_edge  <= cfg_data[1:0];
        pac_pkg::REG_HIDE_DELAY:   hide_delay   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  assign s1_move  = s1_valid && !(out_valid && out_stall);
  assign in_stall = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data <= in_data;
    end
  end

  always_comb begin
    px         = CW'(s1_data.pointer_x);
    py         = CW'(s1_data.pointer_y);
    left_ext   = CW'(panel_left);
    top_ext    = CW'(panel_top);
    width_ext  = signed'(CW'(panel_width));
    height_ext = signed'(CW'(panel_height));
    lo_x = left_ext;
    hi_x = left_ext + width_ext;
    lo_y = top_ext;
    hi_y = top_ext + height_ext;
    if (mode == pac_pkg::MODE_HIDDEN) begin
      case (screen_edge)
        pac_pkg::SIDE_LEFT: begin
          hi_x = left_ext + STRIP_W;
        end
        pac_pkg::SIDE_RIGHT: begin
          lo_x = left_ext + width_ext - STRIP_W;
        end
        pac_pkg::SIDE_TOP: begin
          hi_y = top_ext + STRIP_W;
        end
        default: begin
          lo_y = top_ext + height_ext - STRIP_W;
        end
      endcase
    end
    far = (px < lo_x) || (px > hi_x) || (py < lo_y) || (py > hi_y);
  end

  assign wait_inc = (wait_count == 8'hFF) ? wait_count : wait_count + 8'd1;

  // next state
  always_comb begin
    mode_next       = mode;
    wait_count_next = wait_count;
    case (mode)
      pac_pkg::MODE_WAITING: begin
        if (!far) begin
          mode_next       = pac_pkg::MODE_VISIBLE;
          wait_count_next = '0;
        end else if (wait_inc >= hide_delay) begin
          mode_next       = pac_pkg::MODE_HIDDEN;
          wait_count_next = '0;
        end else begin
          wait_count_next = wait_inc;
        end
      end
      pac_pkg::MODE_HIDDEN: begin
        if (!far) begin
          mode_next = pac_pkg::MODE_VISIBLE;
        end
      end
      default: begin
        mode_next = pac_pkg::MODE_VISIBLE;
        if (far) begin
          mode_next       = pac_pkg::MODE_WAITING;
          wait_count_next = '0;
        end
      end
    endcase
  end

  // result beat
  always_comb begin
    result.mode_now    = mode_next;
    result.panel_shown = (mode_next != pac_pkg::MODE_HIDDEN);
    result.pointer_far = far;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= pac_pkg::MODE_VISIBLE;
      wait_count <= '0;
    end else if (s1_move) begin
      mode       <= mode_next;
      wait_count <= wait_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data <= result;
    end
  end

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !s1_move |=> $stable(mode) && $stable(wait_count))
    else $error("autohide state changed without a beat");

  a_count_only_waiting: assert property (@(posedge clk) disable iff (rst)
    mode != pac_pkg::MODE_WAITING |-> wait_count == 8'd0)
    else $error("wait count nonzero outside waiting");

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid && out_valid)
    else $error("input stalled with nothing held");

endmodule
`default_nettype wire
